// ----- src/rectangular_to_polar_unit_macros.svh -----
// Assertion helpers for the asserting file of the converter.
`ifndef RECTANGULAR_TO_POLAR_UNIT_MACROS_SVH
`define RECTANGULAR_TO_POLAR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during rst.
`define R2P_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during rst.
`define R2P_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/r2p_pkg.sv -----
package r2p_pkg;

  localparam int CORDIC_ITER = 32;
  localparam int DATA_W      = 64;
  localparam int ANG_W       = 35;

  // Pre-rotation stage, the iterations, and the rounding stage.
  localparam int CORDIC_LAT  = CORDIC_ITER + 2;
  // Absolute value, square, sum and rounding stages around the root stages.
  localparam int SQRT_EXTRA  = 4;

  typedef logic signed [DATA_W-1:0] cdata_t;
  typedef logic signed [ANG_W-1:0]  cang_t;

  localparam cang_t HALF_PI = cang_t'(1) <<< 31;
  localparam cang_t FULL_PI = cang_t'(1) <<< 32;

  // round(atan(2^-i) * 2^32 / pi)
  localparam cang_t ATAN_TAB [CORDIC_ITER] = '{
    35'sd1073741824, 35'sd633866811, 35'sd334917815, 35'sd170009512,
    35'sd85334662,   35'sd42708931,  35'sd21359677,  35'sd10680490,
    35'sd5340327,    35'sd2670173,   35'sd1335088,   35'sd667544,
    35'sd333772,     35'sd166886,    35'sd83443,     35'sd41722,
    35'sd20861,      35'sd10430,     35'sd5215,      35'sd2608,
    35'sd1304,       35'sd652,       35'sd326,       35'sd163,
    35'sd81,         35'sd41,        35'sd20,        35'sd10,
    35'sd5,          35'sd3,         35'sd1,         35'sd1
  };

endpackage

// ----- src/r2p_cart_if.sv -----
interface r2p_cart_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, x_coord, y_coord, input ready);
  modport sink (input valid, x_coord, y_coord, output ready);
endinterface

// ----- src/r2p_polar_if.sv -----
interface r2p_polar_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic        [COORD_WIDTH-1:0] magnitude;
  logic signed [COORD_WIDTH-1:0] angle;

  modport source (output valid, magnitude, angle, input ready);
  modport sink (input valid, magnitude, angle, output ready);
endinterface

// ----- src/r2p_cordic.sv -----
module r2p_cordic #(
  parameter int COORD_WIDTH = 16,
  parameter int LATENCY     = 34
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  output logic signed [COORD_WIDTH-1:0] angle
);
  import r2p_pkg::*;

  localparam int SH  = 61 - COORD_WIDTH;
  localparam int OSH = 33 - COORD_WIDTH;
  localparam int PAD = LATENCY - CORDIC_LAT;
  localparam cang_t ROUND_HALF = cang_t'(1) <<< (OSH - 1);

  typedef enum logic [2:0] {
    K_CORDIC,
    K_ZERO,
    K_PI,
    K_POS_HALF,
    K_NEG_HALF
  } kind_t;

  cdata_t xs [CORDIC_ITER+1];
  cdata_t ys [CORDIC_ITER+1];
  cang_t  zs [CORDIC_ITER+1];
  kind_t  ks [CORDIC_ITER+1];

  cdata_t xw;
  cdata_t yw;
  cdata_t x0_next;
  cdata_t y0_next;
  cang_t  z0_next;
  kind_t  k0_next;
  cang_t  zsel;
  cang_t  zrnd;
  logic signed [COORD_WIDTH-1:0] ang_q;

  always_comb begin
    xw = {{(DATA_W-COORD_WIDTH){x_coord[COORD_WIDTH-1]}}, x_coord};
    yw = {{(DATA_W-COORD_WIDTH){y_coord[COORD_WIDTH-1]}}, y_coord};
    xw = xw <<< SH;
    yw = yw <<< SH;

    // Points on an axis get their exact angle at the end.
    if (y_coord == '0) begin
      k0_next = x_coord[COORD_WIDTH-1] ? K_PI : K_ZERO;
    end else if (x_coord == '0) begin
      k0_next = y_coord[COORD_WIDTH-1] ? K_NEG_HALF : K_POS_HALF;
    end else begin
      k0_next = K_CORDIC;
    end

    // A quarter turn brings the left half plane into range of the iterations.
    if (xw[DATA_W-1]) begin
      if (!yw[DATA_W-1]) begin
        x0_next = yw;
        y0_next = -xw;
        z0_next = HALF_PI;
      end else begin
        x0_next = -yw;
        y0_next = xw;
        z0_next = -HALF_PI;
      end
    end else begin
      x0_next = xw;
      y0_next = yw;
      z0_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= x0_next;
      ys[0] <= y0_next;
      zs[0] <= z0_next;
      ks[0] <= k0_next;
      for (int i = 0; i < CORDIC_ITER; i++) begin
        if (!ys[i][DATA_W-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_TAB[i];
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_TAB[i];
        end
        ks[i+1] <= ks[i];
      end
    end
  end

  always_comb begin
    case (ks[CORDIC_ITER])
      K_CORDIC:   zsel = zs[CORDIC_ITER];
      K_ZERO:     zsel = '0;
      K_PI:       zsel = FULL_PI;
      K_POS_HALF: zsel = HALF_PI;
      K_NEG_HALF: zsel = -HALF_PI;
      default:    zsel = '0;
    endcase
    zrnd = zsel + ROUND_HALF;
  end

  // Taking the low bits wraps an angle at or just above +pi to the negative end.
  always_ff @(posedge clk) begin
    if (en) begin
      ang_q <= zrnd[OSH +: COORD_WIDTH];
    end
  end

  generate
    if (PAD > 0) begin : g_pad
      logic signed [COORD_WIDTH-1:0] dly [PAD];
      always_ff @(posedge clk) begin
        if (en) begin
          dly[0] <= ang_q;
          for (int p = 1; p < PAD; p++) begin
            dly[p] <= dly[p-1];
          end
        end
      end
      assign angle = dly[PAD-1];
    end else begin : g_nopad
      assign angle = ang_q;
    end
  endgenerate

endmodule

// ----- src/r2p_isqrt.sv -----
module r2p_isqrt #(
  parameter int COORD_WIDTH = 16,
  parameter int LATENCY     = 20
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  output logic        [COORD_WIDTH-1:0] magnitude
);
  import r2p_pkg::*;

  localparam int SW  = 2 * COORD_WIDTH;
  localparam int RW  = COORD_WIDTH + 2;
  localparam int TW  = COORD_WIDTH + 4;
  localparam int PAD = LATENCY - (COORD_WIDTH + SQRT_EXTRA);

  logic [COORD_WIDTH-1:0] ax;
  logic [COORD_WIDTH-1:0] ay;
  logic [SW-1:0]          sqx;
  logic [SW-1:0]          sqy;

  // One root bit per stage; index 0 is the sum of squares.
  logic [SW-1:0]          ss [COORD_WIDTH+1];
  logic [COORD_WIDTH-1:0] qs [COORD_WIDTH+1];
  logic [RW-1:0]          rs [COORD_WIDTH+1];
  logic [TW-1:0]          trial [COORD_WIDTH];
  logic [TW-1:0]          tval  [COORD_WIDTH];
  logic [COORD_WIDTH-1:0] mag_q;

  always_ff @(posedge clk) begin
    if (en) begin
      ax    <= x_coord[COORD_WIDTH-1] ? (~x_coord + COORD_WIDTH'(1)) : x_coord;
      ay    <= y_coord[COORD_WIDTH-1] ? (~y_coord + COORD_WIDTH'(1)) : y_coord;
      sqx   <= SW'(ax) * SW'(ax);
      sqy   <= SW'(ay) * SW'(ay);
      ss[0] <= sqx + sqy;
      qs[0] <= '0;
      rs[0] <= '0;
    end
  end

  always_comb begin
    for (int k = 0; k < COORD_WIDTH; k++) begin
      trial[k] = {rs[k], ss[k][2*(COORD_WIDTH-1-k) +: 2]};
      tval[k]  = {2'b00, qs[k], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < COORD_WIDTH; k++) begin
        if (trial[k] >= tval[k]) begin
          rs[k+1] <= RW'(trial[k] - tval[k]);
          qs[k+1] <= {qs[k][COORD_WIDTH-2:0], 1'b1};
        end else begin
          rs[k+1] <= trial[k][RW-1:0];
          qs[k+1] <= {qs[k][COORD_WIDTH-2:0], 1'b0};
        end
        ss[k+1] <= ss[k];
      end
      // The remainder is s - q*q; above q the nearer integer is q + 1.
      mag_q <= (rs[COORD_WIDTH] > {2'b00, qs[COORD_WIDTH]})
               ? qs[COORD_WIDTH] + COORD_WIDTH'(1) : qs[COORD_WIDTH];
    end
  end

  generate
    if (PAD > 0) begin : g_pad
      logic [COORD_WIDTH-1:0] dly [PAD];
      always_ff @(posedge clk) begin
        if (en) begin
          dly[0] <= mag_q;
          for (int p = 1; p < PAD; p++) begin
            dly[p] <= dly[p-1];
          end
        end
      end
      assign magnitude = dly[PAD-1];
    end else begin : g_nopad
      assign magnitude = mag_q;
    end
  endgenerate

endmodule

// ----- src/rectangular_to_polar_unit.sv -----
// Channel  Modport  Payload               Direction
// cart     sink     x_coord, y_coord      request in
// polar    source   magnitude, angle      request out
//
// The angle path (one stage per CORDIC iteration) and the root path (one root
// bit per stage) are padded to a common depth, that of the longer path. One
// request is taken per cycle while the output is not stalled. rst clears the
// stage valid bits only. A stalled output holds the whole pipeline, so
// cart.ready follows polar.ready while the last stage is full.
`include "rectangular_to_polar_unit_macros.svh"

module rectangular_to_polar_unit #(
  parameter int COORD_WIDTH = 16
) (
  input logic         clk,
  input logic         rst,
  r2p_cart_if.sink    cart,
  r2p_polar_if.source polar
);
  import r2p_pkg::*;

  localparam int SQRT_LAT = COORD_WIDTH + SQRT_EXTRA;
  localparam int PIPE_LAT = (CORDIC_LAT > SQRT_LAT) ? CORDIC_LAT : SQRT_LAT;

  logic [PIPE_LAT-1:0] vld;
  logic                en;

  assign en         = !vld[PIPE_LAT-1] || polar.ready;
  assign cart.ready = en;
  assign polar.valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], cart.valid};
    end
  end

  r2p_cordic #(
    .COORD_WIDTH (COORD_WIDTH),
    .LATENCY     (PIPE_LAT)
  ) u_cordic (
    .clk     (clk),
    .en      (en),
    .x_coord (cart.x_coord),
    .y_coord (cart.y_coord),
    .angle   (polar.angle)
  );

  r2p_isqrt #(
    .COORD_WIDTH (COORD_WIDTH),
    .LATENCY     (PIPE_LAT)
  ) u_isqrt (
    .clk       (clk),
    .en        (en),
    .x_coord   (cart.x_coord),
    .y_coord   (cart.y_coord),
    .magnitude (polar.magnitude)
  );

  // Only the origin rounds to zero length, and its angle is zero.
  `R2P_ASSERT_IMP(a_origin_angle, polar.valid && polar.magnitude == '0, polar.angle == '0, "zero magnitude with nonzero angle")

  `R2P_ASSERT_IMP(a_stall_hold, !$past(rst) && $past(polar.valid && !polar.ready), $stable(vld), "pipeline moved while output stalled")

  `R2P_ASSERT_NXT(a_accept_enters, cart.valid && cart.ready, vld[0], "accepted request missing from first stage")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int W          = 16;
  localparam int SHIFT_IN   = 61 - W;
  localparam int ROUND_SH   = 33 - W;
  localparam int STEPS      = 32;
  localparam int RANDOM_N   = 1300;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 40;

  localparam longint HALF_TURN = longint'(1) <<< 32;
  localparam longint QUARTER   = longint'(1) <<< 31;

  // Elementary rotation angles, atan(2^-i) in units of pi / 2^32.
  localparam longint ROT_ANGLE [STEPS] = '{
    1073741824, 633866811, 334917815, 170009512, 85334662, 42708931,
    21359677, 10680490, 5340327, 2670173, 1335088, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
    163, 81, 41, 20, 10, 5, 3, 1, 1
  };

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic                typed;
    logic        [W-1:0] magnitude;
    logic signed [W-1:0] angle;
  } point_row_t;

  typedef struct {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic        [W-1:0] magnitude;
    logic signed [W-1:0] angle;
  } polar_point_t;

  localparam int DIRECTED_N = 24;
  localparam point_row_t DIRECTED [DIRECTED_N] = '{
    '{16'sd0,      16'sd0,      1'b1, 16'd0,     16'sd0},
    '{16'sd32767,  16'sd0,      1'b1, 16'd32767, 16'sd0},
    '{-16'sd32768, 16'sd0,      1'b1, 16'd32768, 16'sh8000},
    '{16'sd0,      16'sd32767,  1'b1, 16'd32767, 16'sd16384},
    '{16'sd0,      -16'sd32768, 1'b1, 16'd32768, -16'sd16384},
    '{16'sd1,      16'sd0,      1'b1, 16'd1,     16'sd0},
    '{-16'sd1,     16'sd0,      1'b1, 16'd1,     16'sh8000},
    '{16'sd0,      16'sd1,      1'b1, 16'd1,     16'sd16384},
    '{16'sd0,      -16'sd1,     1'b1, 16'd1,     -16'sd16384},
    '{-16'sd32768, -16'sd32768, 1'b0, 16'd0,     16'sd0},
    '{16'sd32767,  16'sd32767,  1'b0, 16'd0,     16'sd0},
    '{-16'sd32768, 16'sd32767,  1'b0, 16'd0,     16'sd0},
    '{16'sd32767,  -16'sd32768, 1'b0, 16'd0,     16'sd0},
    '{16'sd1,      16'sd1,      1'b0, 16'd0,     16'sd0},
    '{-16'sd1,     16'sd1,      1'b0, 16'd0,     16'sd0},
    '{-16'sd1,     -16'sd1,     1'b0, 16'd0,     16'sd0},
    '{16'sd1,      -16'sd1,     1'b0, 16'd0,     16'sd0},
    '{-16'sd32768, 16'sd1,      1'b0, 16'd0,     16'sd0},
    '{-16'sd32768, -16'sd1,     1'b0, 16'd0,     16'sd0},
    '{-16'sd32767, 16'sd1,      1'b0, 16'd0,     16'sd0},
    '{16'sd3,      16'sd4,      1'b0, 16'd0,     16'sd0},
    '{16'sd12345,  -16'sd6789,  1'b0, 16'd0,     16'sd0},
    '{-16'sd20000, 16'sd30000,  1'b0, 16'd0,     16'sd0},
    '{-16'sd2,     -16'sd32767, 1'b0, 16'd0,     16'sd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  r2p_cart_if  #(.COORD_WIDTH(W)) cart_bus ();
  r2p_polar_if #(.COORD_WIDTH(W)) polar_bus ();

  rectangular_to_polar_unit #(.COORD_WIDTH(W)) dut (
    .clk   (clk),
    .rst   (rst),
    .cart  (cart_bus),
    .polar (polar_bus)
  );

  polar_point_t awaited_polar [$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           calm_send = 1'b0;
  bit           calm_recv = 1'b0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Length by an exact integer root, angle by a 32-step vectoring rotation.
  function automatic polar_point_t polar_of(input logic signed [W-1:0] xc,
                                            input logic signed [W-1:0] yc);
    longint       xs, ys, sq, rem, root, bitv;
    longint       cx, cy, dx, dy, z;
    polar_point_t p;
    xs = xc;
    ys = yc;
    sq = xs * xs + ys * ys;
    rem = sq;
    root = 0;
    bitv = longint'(1) <<< 32;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (sq - root * root > root) root = root + 1;

    if (ys == 0) begin
      z = (xs < 0) ? HALF_TURN : 0;
    end else if (xs == 0) begin
      z = (ys > 0) ? QUARTER : -QUARTER;
    end else begin
      cx = xs <<< SHIFT_IN;
      cy = ys <<< SHIFT_IN;
      z = 0;
      // Points left of the y axis are first turned a quarter turn.
      if (cx < 0) begin
        dx = cx;
        if (cy >= 0) begin
          cx = cy;
          cy = -dx;
          z = QUARTER;
        end else begin
          cx = -cy;
          cy = dx;
          z = -QUARTER;
        end
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + ROT_ANGLE[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - ROT_ANGLE[i];
        end
      end
    end
    z = (z + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;

    p.x = xc;
    p.y = yc;
    p.magnitude = W'(root);
    p.angle = W'(z);
    return p;
  endfunction

  function automatic point_row_t random_point();
    point_row_t row;
    row = '0;
    row.x = W'($urandom);
    row.y = W'($urandom);
    case ($urandom_range(0, 7))
      0: row.y = W'($urandom_range(0, 4)) - W'(2);
      1: row.x = W'($urandom_range(0, 4)) - W'(2);
      2: begin
        // Close to the negative x axis, where the angle wraps.
        row.x = -W'($urandom_range(20000, 32768));
        row.y = W'($urandom_range(0, 6)) - W'(3);
      end
      3: begin
        row.x = W'($urandom_range(0, 64)) - W'(32);
        row.y = W'($urandom_range(0, 64)) - W'(32);
      end
      default: ;
    endcase
    return row;
  endfunction

  task automatic send_point(input point_row_t row);
    int           gap;
    polar_point_t want;
    gap = calm_send ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      cart_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cart_bus.valid   <= 1'b1;
    cart_bus.x_coord <= row.x;
    cart_bus.y_coord <= row.y;
    do @(posedge clk); while (!cart_bus.ready);
    if (row.typed) begin
      want.x = row.x;
      want.y = row.y;
      want.magnitude = row.magnitude;
      want.angle = row.angle;
    end else begin
      want = polar_of(row.x, row.y);
    end
    awaited_polar.push_back(want);
  endtask

  initial begin
    cart_bus.valid   <= 1'b0;
    cart_bus.x_coord <= '0;
    cart_bus.y_coord <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_N; i++) send_point(DIRECTED[i]);
    for (int i = 0; i < RANDOM_N; i++) begin
      if (i % 50 == 0) calm_send = ($urandom_range(0, 3) == 0);
      send_point(random_point());
    end
    cart_bus.valid <= 1'b0;

    while (awaited_polar.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int           stall;
    int           taken;
    polar_point_t want;
    taken = 0;
    polar_bus.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (taken % 40 == 0) calm_recv = ($urandom_range(0, 3) == 0);
      stall = calm_recv ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        polar_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      polar_bus.ready <= 1'b1;
      do @(posedge clk); while (!polar_bus.valid);
      taken++;
      if (awaited_polar.size() == 0) begin
        $display("%0t: result with none expected: magnitude %0d angle %0d", $time,
                 polar_bus.magnitude, polar_bus.angle);
        mismatches++;
      end else begin
        want = awaited_polar.pop_front();
        if (polar_bus.magnitude !== want.magnitude) begin
          $display("%0t: magnitude for (%0d,%0d): expected %0d, actual %0d", $time,
                   want.x, want.y, want.magnitude, polar_bus.magnitude);
          mismatches++;
        end
        if (polar_bus.angle !== want.angle) begin
          $display("%0t: angle for (%0d,%0d): expected %0d, actual %0d", $time,
                   want.x, want.y, want.angle, polar_bus.angle);
          mismatches++;
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (cart_bus.valid && cart_bus.ready) || (polar_bus.valid && polar_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
